// ===== rtl/core/aoc_pkg.sv =====
package aoc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 26;
  localparam int WIDE_W     = 27;
  localparam int ERR_W      = 18;
  localparam int IDX_W      = 11;
  localparam int DZ_W       = 8;
  localparam int TZ_W       = 15;
  localparam int DISC_W     = 10;
  localparam int CNT_W      = 11;
  localparam int DIVR_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int FIRST_SHIFT = 3;

  localparam logic [DZ_W-1:0]   DEADZONE_RST = 8'd8;
  localparam logic [TZ_W-1:0]   TARGET_Z_RST = 15'd16384;
  localparam logic [DISC_W-1:0] DISCARD_RST  = 10'd101;
  localparam logic [CNT_W-1:0]  SAMPLE_RST   = 11'd100;
  localparam logic [CNT_W-1:0]  MAX_COUNT    = 11'd1024;

  localparam logic signed [WIDE_W-1:0] SUM_MAX = 27'sd33554431;
  localparam logic signed [WIDE_W-1:0] SUM_MIN = -27'sd33554432;
  localparam logic signed [WIDE_W-1:0] OFF_MAX = 27'sd32767;
  localparam logic signed [WIDE_W-1:0] OFF_MIN = -27'sd32768;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE,
    REG_TARGET_Z,
    REG_DISCARD,
    REG_SAMPLE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_LATER,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_FIRST,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] offset_x;
    logic signed [SAMPLE_W-1:0] offset_y;
    logic signed [SAMPLE_W-1:0] offset_z;
    logic                       offsets_new;
    logic                       busy_res;
    logic                       done_res;
  } res_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    if (v > OFF_MAX) begin
      return OFF_MAX[SAMPLE_W-1:0];
    end else if (v < OFF_MIN) begin
      return OFF_MIN[SAMPLE_W-1:0];
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/aoc_if.sv =====
interface aoc_cmd_if import aoc_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aoc_res_if import aoc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/aoc_div.sv =====
module aoc_div import aoc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIVR_W-1:0]       divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              running;
  logic [STEP_W-1:0] step_cnt;
  logic [SUM_W-1:0]  quo;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic              neg;

  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              ge;
  logic [SUM_W-1:0]  mag;

  assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem, quo[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  assign quotient = neg ? -$signed(quo) : $signed(quo);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step_cnt <= '0;
      end else if (running) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (running) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

endmodule

// ===== rtl/core/accel_offset_calibrator_top.sv =====
// a beat that does not close a measuring pass goes to the emit state and its result is
// registered in the output register once that is free; a beat that closes a pass runs three
// mean divisions and up to three deadzone divisions on one shared 26-step serial divider
// throughput: one beat at a time, ready is low until the result is handed to the output register
// reset: synchronous, clears phase, pass counters, sums and offsets, registers return to defaults
module accel_offset_calibrator_top import aoc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  aoc_cmd_if.sink               cmd,
  aoc_res_if.source             res
);

  logic [DZ_W-1:0]   deadzone;
  logic [TZ_W-1:0]   target_z;
  logic [DISC_W-1:0] discard_count;
  logic [CNT_W-1:0]  sample_count;

  state_t state, state_next;
  phase_t phase;

  logic [IDX_W-1:0]           sample_index;
  logic signed [SUM_W-1:0]    sum_x, sum_y, sum_z;
  logic signed [SAMPLE_W-1:0] offset_reg_x, offset_reg_y, offset_reg_z;
  logic signed [SAMPLE_W-1:0] mean_x, mean_y, mean_z;
  logic [1:0]                 axis;
  logic                       corr;
  logic [2:0]                 settled;
  logic                       fresh;
  logic                       out_valid;
  res_t                       out_data;

  logic [CNT_W-1:0]         cnt_eff;
  logic [DZ_W-1:0]          dz_eff;
  logic                     accept;
  logic                     acc_on;
  logic [IDX_W-1:0]         idx_inc;
  logic                     pass_end;
  logic                     active;
  logic signed [ERR_W-1:0]  err_x, err_y, err_z, sel_err;
  logic [ERR_W-1:0]         mag;
  logic                     settled_now;
  logic signed [SUM_W-1:0]  sel_sum;
  logic signed [SAMPLE_W-1:0] sel_off;
  logic signed [SAMPLE_W-1:0] off_new;
  logic signed [SAMPLE_W-1:0] mean_new;
  logic                     div_start;
  logic signed [SUM_W-1:0]  div_dividend;
  logic [DIVR_W-1:0]        div_divisor;
  logic                     div_done;
  logic signed [SUM_W-1:0]  div_q;
  logic                     slot_free;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                       input logic signed [SAMPLE_W-1:0] a);
    logic signed [WIDE_W-1:0] t;
    t = WIDE_W'(s) + WIDE_W'(a);
    if (t > SUM_MAX) begin
      return SUM_MAX[SUM_W-1:0];
    end else if (t < SUM_MIN) begin
      return SUM_MIN[SUM_W-1:0];
    end else begin
      return t[SUM_W-1:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] first_off(input logic signed [ERR_W-1:0] e);
    logic signed [ERR_W-1:0] t;
    t = e + (e[ERR_W-1] ? ERR_W'((1 << FIRST_SHIFT) - 1) : ERR_W'(0));
    return sat16(WIDE_W'(t >>> FIRST_SHIFT));
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone      <= DEADZONE_RST;
      target_z      <= TARGET_Z_RST;
      discard_count <= DISCARD_RST;
      sample_count  <= SAMPLE_RST;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_DEADZONE: deadzone      <= wr_data[DZ_W-1:0];
        REG_TARGET_Z: target_z      <= wr_data[TZ_W-1:0];
        REG_DISCARD:  discard_count <= wr_data[DISC_W-1:0];
        REG_SAMPLE:   sample_count  <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt_eff = (sample_count == '0) ? CNT_W'(1) :
                   (sample_count > MAX_COUNT) ? MAX_COUNT : sample_count;
  assign dz_eff  = (deadzone == '0) ? DZ_W'(1) : deadzone;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign active    = (phase == PH_FIRST) || (phase == PH_LATER);
  assign acc_on    = sample_index >= IDX_W'(discard_count);
  assign idx_inc   = sample_index + 1'b1;
  assign pass_end  = {1'b0, idx_inc} >= ({2'b0, discard_count} + {1'b0, cnt_eff});

  assign err_x = -ERR_W'(mean_x);
  assign err_y = -ERR_W'(mean_y);
  assign err_z = $signed({3'b0, target_z}) - ERR_W'(mean_z);

  always_comb begin
    case (axis)
      2'd0: begin
        sel_err = err_x;
        sel_sum = sum_x;
        sel_off = offset_reg_x;
      end
      2'd1: begin
        sel_err = err_y;
        sel_sum = sum_y;
        sel_off = offset_reg_y;
      end
      default: begin
        sel_err = err_z;
        sel_sum = sum_z;
        sel_off = offset_reg_z;
      end
    endcase
  end

  assign mag         = sel_err[ERR_W-1] ? ERR_W'(-sel_err) : ERR_W'(sel_err);
  assign settled_now = mag <= ERR_W'(dz_eff);

  assign div_start    = (state == ST_DIV_GO);
  assign div_dividend = corr ? SUM_W'(sel_err) : sel_sum;
  assign div_divisor  = corr ? DIVR_W'(dz_eff) : cnt_eff;

  assign mean_new = sat16(WIDE_W'(div_q));
  assign off_new  = sat16(WIDE_W'(sel_off) + WIDE_W'(div_q));

  aoc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign slot_free = !out_valid || res.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.data.func == FUNC_SAMPLE && active && pass_end) begin
            state_next = ST_DIV_GO;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (axis != 2'd2) begin
            state_next = corr ? ST_CHECK : ST_DIV_GO;
          end else if (corr) begin
            state_next = ST_FINISH;
          end else begin
            state_next = (phase == PH_FIRST) ? ST_FIRST : ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!settled_now) begin
          state_next = ST_DIV_GO;
        end else if (axis == 2'd2) begin
          state_next = ST_FINISH;
        end
      end
      ST_FIRST:  state_next = ST_EMIT;
      ST_FINISH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sample_index <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      offset_reg_x <= '0;
      offset_reg_y <= '0;
      offset_reg_z <= '0;
      axis         <= '0;
      corr         <= 1'b0;
      settled      <= '0;
      fresh        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fresh <= 1'b0;
            axis  <= '0;
            corr  <= 1'b0;
            if (cmd.data.func == FUNC_START) begin
              offset_reg_x <= '0;
              offset_reg_y <= '0;
              offset_reg_z <= '0;
              sample_index <= '0;
              sum_x        <= '0;
              sum_y        <= '0;
              sum_z        <= '0;
              phase        <= PH_FIRST;
              fresh        <= 1'b1;
            end else if (active) begin
              if (acc_on) begin
                sum_x <= sat_add(sum_x, cmd.data.accel_x);
                sum_y <= sat_add(sum_y, cmd.data.accel_y);
                sum_z <= sat_add(sum_z, cmd.data.accel_z);
              end
              sample_index <= idx_inc;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (!corr) begin
              case (axis)
                2'd0:    mean_x <= mean_new;
                2'd1:    mean_y <= mean_new;
                default: mean_z <= mean_new;
              endcase
              if (axis == 2'd2) begin
                axis    <= '0;
                corr    <= 1'b1;
                settled <= '0;
              end else begin
                axis <= axis + 1'b1;
              end
            end else begin
              case (axis)
                2'd0:    offset_reg_x <= off_new;
                2'd1:    offset_reg_y <= off_new;
                default: offset_reg_z <= off_new;
              endcase
              if (axis != 2'd2) begin
                axis <= axis + 1'b1;
              end
            end
          end
        end
        ST_CHECK: begin
          if (settled_now) begin
            settled[axis] <= 1'b1;
            if (axis != 2'd2) begin
              axis <= axis + 1'b1;
            end
          end
        end
        ST_FIRST: begin
          offset_reg_x <= first_off(err_x);
          offset_reg_y <= first_off(err_y);
          offset_reg_z <= first_off(err_z);
          phase        <= PH_LATER;
          fresh        <= 1'b1;
          sample_index <= '0;
          sum_x        <= '0;
          sum_y        <= '0;
          sum_z        <= '0;
        end
        ST_FINISH: begin
          if (&settled) begin
            phase <= PH_DONE;
          end else begin
            fresh <= 1'b1;
          end
          sample_index <= '0;
          sum_x        <= '0;
          sum_y        <= '0;
          sum_z        <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_data.offset_x    <= offset_reg_x;
      out_data.offset_y    <= offset_reg_y;
      out_data.offset_z    <= offset_reg_z;
      out_data.offsets_new <= fresh;
      out_data.busy_res    <= active;
      out_data.done_res    <= (phase == PH_DONE);
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule

// ===== bench/tb_accel_offset_calibrator_top.sv =====
`timescale 1ns / 1ps

module tb_accel_offset_calibrator_top;
  import aoc_pkg::*;

  localparam int     LONG_HOLD  = 400;
  localparam int     TAIL_WAIT  = 200;
  localparam longint FIRST_DIV  = longint'(1) << FIRST_SHIFT;
  localparam int     RAND_BEATS = 200;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  aoc_cmd_if cmd ();
  aoc_res_if res ();

  accel_offset_calibrator_top dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .cmd(cmd),
    .res(res)
  );

  // calibrator state as predicted
  phase_t            cal_phase;
  logic [IDX_W-1:0]  pass_index;
  longint            acc_x, acc_y, acc_z;
  longint            off_x, off_y, off_z;
  logic [DZ_W-1:0]   dz_reg;
  logic [TZ_W-1:0]   tz_reg;
  logic [DISC_W-1:0] disc_reg;
  logic [CNT_W-1:0]  cnt_reg;

  res_t pending_offsets[$];

  int beats_sent = 0;
  int live_beats = 0;
  int results_checked = 0;
  int passes_closed = 0;
  int settles = 0;
  int mismatches = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit in_deadzone(longint err, longint dz);
    return ((err < 0) ? -err : err) <= dz;
  endfunction

  function automatic longint nudged(longint off, longint err, longint dz);
    return in_deadzone(err, dz) ? off : clamp(off + err / dz, OFF_MIN, OFF_MAX);
  endfunction

  function automatic void model_reset();
    dz_reg = DEADZONE_RST;
    tz_reg = TARGET_Z_RST;
    disc_reg = DISCARD_RST;
    cnt_reg = SAMPLE_RST;
    cal_phase = PH_IDLE;
    pass_index = '0;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    off_x = 0;
    off_y = 0;
    off_z = 0;
  endfunction

  function automatic res_t calibration_step(cmd_t b);
    res_t   r;
    bit     fresh;
    longint cnt, dz, mx, my, mz, ez;
    fresh = 1'b0;
    if (b.func == FUNC_START) begin
      off_x = 0;
      off_y = 0;
      off_z = 0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      pass_index = '0;
      cal_phase = PH_FIRST;
      fresh = 1'b1;
    end else if (cal_phase == PH_FIRST || cal_phase == PH_LATER) begin
      cnt = (cnt_reg == 0) ? 1 :
            ((cnt_reg > MAX_COUNT) ? longint'(MAX_COUNT) : longint'(cnt_reg));
      dz = (dz_reg == 0) ? 1 : longint'(dz_reg);
      if (pass_index >= disc_reg) begin
        acc_x = clamp(acc_x + longint'(b.accel_x), SUM_MIN, SUM_MAX);
        acc_y = clamp(acc_y + longint'(b.accel_y), SUM_MIN, SUM_MAX);
        acc_z = clamp(acc_z + longint'(b.accel_z), SUM_MIN, SUM_MAX);
      end
      pass_index = pass_index + 1'b1;
      if (longint'(pass_index) >= longint'(disc_reg) + cnt) begin
        mx = clamp(acc_x / cnt, OFF_MIN, OFF_MAX);
        my = clamp(acc_y / cnt, OFF_MIN, OFF_MAX);
        mz = clamp(acc_z / cnt, OFF_MIN, OFF_MAX);
        ez = longint'(tz_reg) - mz;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        pass_index = '0;
        passes_closed++;
        if (cal_phase == PH_FIRST) begin
          off_x = clamp(-mx / FIRST_DIV, OFF_MIN, OFF_MAX);
          off_y = clamp(-my / FIRST_DIV, OFF_MIN, OFF_MAX);
          off_z = clamp(ez / FIRST_DIV, OFF_MIN, OFF_MAX);
          cal_phase = PH_LATER;
          fresh = 1'b1;
        end else if (in_deadzone(mx, dz) && in_deadzone(my, dz) && in_deadzone(ez, dz)) begin
          cal_phase = PH_DONE;
          settles++;
        end else begin
          off_x = nudged(off_x, -mx, dz);
          off_y = nudged(off_y, -my, dz);
          off_z = nudged(off_z, ez, dz);
          fresh = 1'b1;
        end
      end
    end
    r.offset_x = off_x[SAMPLE_W-1:0];
    r.offset_y = off_y[SAMPLE_W-1:0];
    r.offset_z = off_z[SAMPLE_W-1:0];
    r.offsets_new = fresh;
    r.busy_res = (cal_phase == PH_FIRST || cal_phase == PH_LATER);
    r.done_res = (cal_phase == PH_DONE);
    return r;
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic cmd_t beat(logic f, int x, int y, int z);
    cmd_t b;
    b.func = f;
    b.accel_x = SAMPLE_W'(clamp(x, -32768, 32767));
    b.accel_y = SAMPLE_W'(clamp(y, -32768, 32767));
    b.accel_z = SAMPLE_W'(clamp(z, -32768, 32767));
    return b;
  endfunction

  task automatic send_beat(cmd_t b);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data <= b;
    do @(posedge clk); while (!cmd.ready);
    if (b.func == FUNC_START || cal_phase == PH_FIRST || cal_phase == PH_LATER) begin
      live_beats++;
    end
    beats_sent++;
    pending_offsets.push_back(calibration_step(b));
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_DATA_W'(value);
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEADZONE: dz_reg = value[DZ_W-1:0];
      REG_TARGET_Z: tz_reg = value[TZ_W-1:0];
      REG_DISCARD: disc_reg = value[DISC_W-1:0];
      default: cnt_reg = value[CNT_W-1:0];
    endcase
  endtask

  task automatic configure(int dz, int tz, int disc, int cnt);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_TARGET_Z, tz);
    write_reg(REG_DISCARD, disc);
    write_reg(REG_SAMPLE, cnt);
  endtask

  task automatic flag_mismatch(string field, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s at result %0d: expected %0d, got %0d",
               field, results_checked, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res.valid && res.ready) begin
      results_checked++;
      if (pending_offsets.size() == 0) begin
        flag_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = pending_offsets.pop_front();
        if (res.data.offset_x !== want.offset_x)
          flag_mismatch("offset_x", want.offset_x, res.data.offset_x);
        if (res.data.offset_y !== want.offset_y)
          flag_mismatch("offset_y", want.offset_y, res.data.offset_y);
        if (res.data.offset_z !== want.offset_z)
          flag_mismatch("offset_z", want.offset_z, res.data.offset_z);
        if (res.data.offsets_new !== want.offsets_new)
          flag_mismatch("offsets_new", want.offsets_new, res.data.offsets_new);
        if (res.data.busy_res !== want.busy_res)
          flag_mismatch("busy_res", want.busy_res, res.data.busy_res);
        if (res.data.done_res !== want.done_res)
          flag_mismatch("done_res", want.done_res, res.data.done_res);
      end
    end
  end

  initial begin : rx_pacing
    bit held;
    held = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic test_idle_samples();
    send_beat(beat(FUNC_SAMPLE, 32767, -32768, 0));
    send_beat(beat(FUNC_SAMPLE, -1, 0, -32768));
  endtask

  task automatic test_pass_sequence();
    drain();
    configure(8, 2047, 1, 2);
    send_beat(beat(FUNC_START, 0, 0, 0));
    send_beat(beat(FUNC_SAMPLE, 32767, -32768, -1));
    send_beat(beat(FUNC_SAMPLE, -32768, 32767, 0));
    send_beat(beat(FUNC_SAMPLE, -32768, 32767, -32768));
    // x still outside the deadzone, y and z settled
    send_beat(beat(FUNC_SAMPLE, 0, 0, 0));
    send_beat(beat(FUNC_SAMPLE, 20, 3, 2047));
    send_beat(beat(FUNC_SAMPLE, 20, 3, 2047));
    // everything inside, exactly at the edge on x
    send_beat(beat(FUNC_SAMPLE, 0, 0, 0));
    send_beat(beat(FUNC_SAMPLE, 7, -2, 2040));
    send_beat(beat(FUNC_SAMPLE, 9, -4, 2055));
    send_beat(beat(FUNC_SAMPLE, -1, -1, -1));
    send_beat(beat(FUNC_START, 5, 5, 5));
    send_beat(beat(FUNC_SAMPLE, 100, 200, 300));
    send_beat(beat(FUNC_START, -5, -5, -5));
    send_beat(beat(FUNC_SAMPLE, 1, 2, 3));
  endtask

  task automatic test_deadzone_zero();
    drain();
    configure(0, 0, 0, 1);
    send_beat(beat(FUNC_START, 0, 0, 0));
    send_beat(beat(FUNC_SAMPLE, 100, -100, 0));
    send_beat(beat(FUNC_SAMPLE, 2, -2, 3));
    send_beat(beat(FUNC_SAMPLE, 1, -1, -1));
    send_beat(beat(FUNC_SAMPLE, 9, 9, 9));
  endtask

  task automatic test_extreme_registers();
    drain();
    configure(255, 32767, 5, 0);
    send_beat(beat(FUNC_START, 0, 0, 0));
    repeat (24) send_beat(beat(FUNC_SAMPLE, rnd16(), rnd16(), rnd16()));
  endtask

  // sums and means pushed into saturation by moving the pass window mid-pass
  task automatic test_sum_overflow();
    drain();
    configure(1, 0, 0, 2047);
    send_beat(beat(FUNC_START, 0, 0, 0));
    repeat (1000) send_beat(beat(FUNC_SAMPLE, -32768, 32767, -32768));
    drain();
    write_reg(REG_DISCARD, 1000);
    repeat (30) send_beat(beat(FUNC_SAMPLE, -32768, 32767, -32768));
    drain();
    write_reg(REG_DISCARD, 1023);
    write_reg(REG_SAMPLE, 1);
    send_beat(beat(FUNC_SAMPLE, -32768, 32767, -32768));
    drain();
    write_reg(REG_DISCARD, 0);
    repeat (3) send_beat(beat(FUNC_SAMPLE, -32768, 32767, -32768));
  endtask

  task automatic test_backpressure();
    drain();
    configure(8, 1000, 0, 2);
    hold_req = 1'b1;
    send_beat(beat(FUNC_START, 0, 0, 0));
    repeat (40) send_beat(beat(FUNC_SAMPLE, int'($urandom_range(0, 40)) - 20,
                                int'($urandom_range(0, 40)) - 20,
                                1000 + int'($urandom_range(0, 40)) - 20));
  endtask

  function automatic int pick_center(int base, int dz);
    case ($urandom_range(0, 3))
      0: return base + int'($urandom_range(0, 2 * dz)) - dz;
      1: return base + int'($urandom_range(0, 6 * dz)) - 3 * dz;
      2: return rnd16();
      default: return ($urandom_range(0, 1) == 1) ? base + dz + int'($urandom_range(0, 1)) :
                                                    base - dz - int'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic calibration_run();
    int dze, cnte, n, cx, cy, cz, amp;
    dze = (dz_reg == 0) ? 1 : int'(dz_reg);
    cnte = (cnt_reg == 0) ? 1 : ((cnt_reg > MAX_COUNT) ? int'(MAX_COUNT) : int'(cnt_reg));
    n = $urandom_range(1, 4 * (int'(disc_reg) + cnte) + 2);
    cx = pick_center(0, dze);
    cy = pick_center(0, dze);
    cz = pick_center(int'(tz_reg), dze);
    amp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 3);
    send_beat(beat(FUNC_START, rnd16(), rnd16(), rnd16()));
    repeat (n) begin
      send_beat(beat(FUNC_SAMPLE, cx + int'($urandom_range(0, 2 * amp)) - amp,
                     cy + int'($urandom_range(0, 2 * amp)) - amp,
                     cz + int'($urandom_range(0, 2 * amp)) - amp));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      send_beat(beat(($urandom_range(0, 1) == 1) ? FUNC_SAMPLE : FUNC_START,
                     rnd16(), rnd16(), rnd16()));
    end
  endtask

  task automatic test_random(int total);
    int goal;
    for (int p = 0; p < 8; p++) begin
      drain();
      calm = (p == 7);
      case (p)
        0: configure(1, 0, 0, 1);
        1: configure(255, 2047, 3, 8);
        2: configure(0, $urandom_range(0, 32767), $urandom_range(0, 4), 0);
        default: configure($urandom_range(0, 60), $urandom_range(0, 32767),
                           $urandom_range(0, 6), $urandom_range(0, 12));
      endcase
      goal = live_beats + total / 8;
      while (live_beats < goal) begin
        if ($urandom_range(0, 6) == 0) begin
          noise_burst();
        end else begin
          calibration_run();
        end
      end
    end
  endtask

  initial begin : run
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_DEADZONE;
    wr_data <= '0;
    cmd.valid <= 1'b0;
    cmd.data <= '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_samples();
    test_pass_sequence();
    test_deadzone_zero();
    test_extreme_registers();
    test_sum_overflow();
    test_backpressure();
    test_random(RAND_BEATS);
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("sent %0d beats (%0d during calibration) and checked %0d results",
             beats_sent, live_beats, results_checked);
    $display("%0d measuring passes closed, %0d calibrations settled, %0d mismatches",
             passes_closed, settles, mismatches);
    if (mismatches == 0 && pending_offsets.size() == 0) begin
      $display("tb_accel_offset_calibrator_top: PASS");
    end else begin
      $display("tb_accel_offset_calibrator_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(30_000_000);
    $display("timeout with %0d results outstanding", pending_offsets.size());
    $display("tb_accel_offset_calibrator_top: FAIL");
    $finish;
  end

endmodule
